[sv/ped_pkg.sv]
// shared types and constants for the percent escape decoder
// no dependencies; used by every module of the block

package ped_pkg;

    // escape character and hex radix
    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam int unsigned HEX_RADIX = 16;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // most bytes one input transaction can produce
    localparam int unsigned MAX_RESULTS = 3;

    typedef logic [7:0] t_byte;

    // input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    // output transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // escape tracking mode
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_PCT   = 2'd1,
        MODE_DIGIT = 2'd2
    } t_mode;

    // work handed from front to back: one to three bytes, last flag on the final one
    typedef struct packed {
        logic [1:0]                   cnt;
        logic                         last;
        logic [MAX_RESULTS-1:0][7:0]  bytes;
    } t_cmd;

endpackage

[sv/ped_front.sv]
// front end: classifies each input byte against the escape state
// and builds the list of bytes to emit; depends on ped_pkg

module ped_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  ped_pkg::t_in  i_in,
    output logic          o_push,
    output ped_pkg::t_cmd o_cmd
);

    ped_pkg::t_mode r_mode, n_mode;
    ped_pkg::t_byte r_held, n_held;

    logic       is_hex;
    logic [3:0] cur_nib;
    logic [3:0] held_nib;
    logic       fresh_emits;
    logic       fresh_pct;

    // value of a hex digit, valid flag separately
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    // byte classification
    assign is_hex      = hex_ok(i_in.in_byte);
    assign cur_nib     = hex_nib(i_in.in_byte);
    assign held_nib    = hex_nib(r_held);
    assign fresh_pct   = (i_in.in_byte == ped_pkg::PCT_CHAR) && !i_in.in_last;
    assign fresh_emits = !fresh_pct;

    // next mode and held digit
    always_comb begin
        n_mode = r_mode;
        n_held = r_held;
        if (i_accept) begin
            n_held = '0;
            unique case (r_mode)
                ped_pkg::MODE_PCT: begin
                    if (is_hex && !i_in.in_last) begin
                        n_mode = ped_pkg::MODE_DIGIT;
                        n_held = i_in.in_byte;
                    end else if (is_hex) begin
                        n_mode = ped_pkg::MODE_IDLE;
                    end else begin
                        n_mode = fresh_pct ? ped_pkg::MODE_PCT : ped_pkg::MODE_IDLE;
                    end
                end
                ped_pkg::MODE_DIGIT: begin
                    if (is_hex) begin
                        n_mode = ped_pkg::MODE_IDLE;
                    end else begin
                        n_mode = fresh_pct ? ped_pkg::MODE_PCT : ped_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    n_mode = fresh_pct ? ped_pkg::MODE_PCT : ped_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // bytes produced by this transaction
    always_comb begin
        o_cmd      = '0;
        o_cmd.last = i_in.in_last;
        unique case (r_mode)
            ped_pkg::MODE_PCT: begin
                o_cmd.bytes[0] = ped_pkg::PCT_CHAR;
                if (is_hex) begin
                    o_cmd.cnt      = i_in.in_last ? 2'd2 : 2'd0;
                    o_cmd.bytes[1] = i_in.in_byte;
                end else begin
                    o_cmd.cnt      = fresh_emits ? 2'd2 : 2'd1;
                    o_cmd.bytes[1] = i_in.in_byte;
                end
            end
            ped_pkg::MODE_DIGIT: begin
                if (is_hex) begin
                    o_cmd.cnt      = 2'd1;
                    o_cmd.bytes[0] = {held_nib, cur_nib};
                end else begin
                    o_cmd.cnt      = fresh_emits ? 2'd3 : 2'd2;
                    o_cmd.bytes[0] = ped_pkg::PCT_CHAR;
                    o_cmd.bytes[1] = r_held;
                    o_cmd.bytes[2] = i_in.in_byte;
                end
            end
            default: begin
                o_cmd.cnt      = fresh_emits ? 2'd1 : 2'd0;
                o_cmd.bytes[0] = i_in.in_byte;
            end
        endcase
    end

    // nothing to queue when the byte is only held
    assign o_push = i_accept && (o_cmd.cnt != 2'd0);

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ped_pkg::MODE_IDLE;
            r_held <= '0;
        end else begin
            r_mode <= n_mode;
            r_held <= n_held;
        end
    end

endmodule

[sv/ped_queue.sv]
// short queue of decode commands between front and back
// depends on ped_pkg

module ped_queue #(
    parameter int unsigned DEPTH = ped_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ped_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output ped_pkg::t_cmd o_data,
    output logic          o_valid
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ped_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[sv/ped_back.sv]
// back end: walks the bytes of each queued command into the output register
// depends on ped_pkg

module ped_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  ped_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output ped_pkg::t_out o_out
);

    logic [1:0]    r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    ped_pkg::t_out r_out;

    logic load;
    logic at_end;

    // output register frees when empty or being taken
    assign load   = i_cmd_valid && (!r_out_valid || i_pop);
    assign at_end = (r_idx == i_cmd.cnt - 2'd1);

    assign o_cmd_pop = load && at_end;
    assign o_empty   = !r_out_valid;
    assign o_out     = r_out;

    // byte index and output valid
    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            n_idx       = at_end ? 2'd0 : r_idx + 2'd1;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte <= i_cmd.bytes[r_idx];
            r_out.out_last <= i_cmd.last && at_end;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[sv/percent_escape_decoder.sv]
// percent escape decoder: one byte taken per cycle while o_full is low
// the first decoded byte of a transaction is written to the command queue and then loaded
//   into the output register when nothing is queued ahead of it
// throughput: one input per cycle into a QUEUE_DEPTH command queue while it is not full;
//   one decoded byte per cycle leaves through the output register while i_pop is high
// reset: synchronous, active low; clears escape mode, queue and output valid flag
// depends on ped_pkg, ped_front, ped_queue, ped_back

module percent_escape_decoder #(
    parameter int unsigned QUEUE_DEPTH = ped_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  ped_pkg::t_in  i_in,
    output logic          o_empty,
    input  logic          i_pop,
    output ped_pkg::t_out o_out
);

    logic          accept;
    logic          cmd_push;
    ped_pkg::t_cmd cmd_wr;
    ped_pkg::t_cmd cmd_rd;
    logic          cmd_valid;
    logic          cmd_pop;

    assign accept = i_push && !o_full;

    // classify and build commands
    ped_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_push   (cmd_push),
        .o_cmd    (cmd_wr)
    );

    // decoupling queue
    ped_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_wr),
        .o_full  (o_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_rd),
        .o_valid (cmd_valid)
    );

    // emit bytes
    ped_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_rd),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out       (o_out)
    );

endmodule

[sv/ped_checker.sv]
// port-level checks for the percent escape decoder, bound to the top level
// depends on ped_pkg

module ped_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_full,
    input logic          o_empty,
    input logic          i_pop,
    input ped_pkg::t_out o_out
);

    // reset leaves nothing to read
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("output not empty after reset");

    // reset leaves the queue open
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("queue full after reset");

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_out))
        else $error("waiting result changed");

    // a full queue always feeds an empty output register next cycle
    a_full_feeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && o_empty |=> !o_empty)
        else $error("queue full but output stayed empty");

endmodule

bind percent_escape_decoder ped_checker u_ped_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_full  (o_full),
    .o_empty (o_empty),
    .i_pop   (i_pop),
    .o_out   (o_out)
);
